// ----- rtl/ecm_pkg.sv -----
// Shared types and constants for the exchange matrix contraction block.
package ecm_pkg;

   localparam int MAX_ORBITALS = 64;
   localparam int NUM_SETS     = 4;
   localparam int ORB_W        = $clog2(MAX_ORBITALS);
   localparam int SET_W        = $clog2(NUM_SETS);
   localparam int ADDR_W       = SET_W + 2 * ORB_W;
   localparam int STORE_DEPTH  = NUM_SETS * MAX_ORBITALS * MAX_ORBITALS;
   localparam int VAL_W        = 32;
   localparam int ACC_W        = 48;
   localparam int FRAC_W       = 24;
   localparam int PROD_W       = 2 * VAL_W;
   localparam int CFG_W        = 7;
   localparam int UPD_W        = 2;
   localparam logic [CFG_W-1:0] ORBITALS_RESET = CFG_W'(MAX_ORBITALS);

   typedef enum logic [1:0] {
      MODE_LOAD_DENSITY = 2'd0,
      MODE_PRESET       = 2'd1,
      MODE_APPLY        = 2'd2,
      MODE_READ         = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [1:0]         matrix_set;
      logic [5:0]         orb_i;
      logic [5:0]         orb_j;
      logic [5:0]         orb_k;
      logic [5:0]         orb_l;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [47:0] read_value;
      logic               saturated;
      logic               index_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_ISSUE,
      ST_MULT,
      ST_WRITE,
      ST_READ_WAIT
   } state_type;

   typedef struct packed {
      logic             clear_step;
      logic             capture;
      logic             write_density;
      logic             write_preset;
      logic             issue_rd;
      logic             mult;
      logic             acc_write;
      logic             rsp_load;
      logic [UPD_W-1:0] upd;
   } cmd_type;

   typedef struct packed {
      logic     clear_last;
      logic     err;
      mode_type mode;
      logic     rsp_busy;
   } status_type;

endpackage

// ----- rtl/exchange_matrix_contract.sv -----
// Top level of the exchange matrix contraction block: controller plus datapath.
// Load and preset items and index errors are answered from the dispatch state, reads
// wait for the exchange memory read, and an applied integral makes four read,
// multiply, write passes. Only one item is in flight at a time; the four passes run
// serially on the exchange memory, which has one write port and one read port.
// Reset: synchronous; afterwards a clearing pass zeroes all 16384 entries of the exchange
// memory while the input is stalled; the register may be written during it.
module exchange_matrix_contract (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ecm_pkg::req_type    req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ecm_pkg::rsp_type    rsp_payload,
   input  logic                csr_wr_en,
   input  logic [6:0]          csr_wr_data
);
   import ecm_pkg::*;

   // The controller sees status and drives commands; the data storage is in the datapath.
   cmd_type    cmd;
   status_type status;

   ecm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the item, both memories and the result register, which
   // is free again once taken so the next item can be accepted in the same cycle.
   ecm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ----- rtl/ecm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ecm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ecm_ctrl.sv -----
// Controller state machine that sequences clearing, item dispatch and the four updates.
module ecm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ecm_pkg::status_type status,
   output ecm_pkg::cmd_type    cmd
);
   import ecm_pkg::*;

   state_type        state_ff, state_in;
   logic [UPD_W-1:0] upd_ff, upd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         upd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         upd_ff   <= upd_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      upd_in    = upd_ff;
      cmd       = '0;
      cmd.upd   = upd_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = status.rsp_busy;
            if (req_valid && !status.rsp_busy) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            upd_in = '0;
            if (status.err) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               unique case (status.mode)
                  MODE_LOAD_DENSITY: begin
                     cmd.write_density = 1'b1;
                     cmd.rsp_load      = 1'b1;
                     state_in          = ST_IDLE;
                  end
                  MODE_PRESET: begin
                     cmd.write_preset = 1'b1;
                     cmd.rsp_load     = 1'b1;
                     state_in         = ST_IDLE;
                  end
                  MODE_APPLY: begin
                     state_in = ST_ISSUE;
                  end
                  MODE_READ: begin
                     cmd.issue_rd = 1'b1;
                     state_in     = ST_READ_WAIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.issue_rd = 1'b1;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.acc_write = 1'b1;
            if (upd_ff == UPD_W'(3)) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               upd_in   = upd_ff + UPD_W'(1);
               state_in = ST_ISSUE;
            end
         end
         ST_READ_WAIT: begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/ecm_datapath.sv -----
// Datapath: item register, density and exchange memories, multiply-accumulate and result register.
module ecm_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ecm_pkg::req_type     req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ecm_pkg::rsp_type     rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [6:0]           csr_wr_data,
   input  ecm_pkg::cmd_type     cmd,
   output ecm_pkg::status_type  status
);
   import ecm_pkg::*;

   logic [CFG_W-1:0]         orbitals_ff;
   logic [ADDR_W-1:0]        clr_ff;
   req_type                  item_ff;
   logic                     err_ff, err_in;
   logic                     sat_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  kold_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic [CFG_W-1:0]         lim;
   logic [ORB_W-1:0]         k_row, k_col, d_row, d_col;
   logic [ADDR_W-1:0]        k_addr, d_addr, k_wr_addr;
   logic                     k_wr_en;
   logic [ACC_W-1:0]         k_wr_data;
   logic [ACC_W-1:0]         k_rd_data;
   logic [VAL_W-1:0]         d_rd_data;
   logic signed [PROD_W-FRAC_W-1:0] scaled;
   logic signed [ACC_W:0]    sum;
   logic                     sum_ovf;
   logic [ACC_W-1:0]         sum_sat;

   // Limit is the smaller of the register and the store size.
   assign lim = (orbitals_ff < CFG_W'(MAX_ORBITALS)) ? orbitals_ff : CFG_W'(MAX_ORBITALS);

   always_comb begin
      err_in = ({1'b0, req_payload.matrix_set} >= (SET_W + 1)'(NUM_SETS))
            || (CFG_W'(req_payload.orb_i) >= lim)
            || (CFG_W'(req_payload.orb_j) >= lim);
      if (req_payload.mode == MODE_APPLY) begin
         err_in = err_in || (CFG_W'(req_payload.orb_k) >= lim)
                         || (CFG_W'(req_payload.orb_l) >= lim);
      end
   end

   // Update order: K(i,l)+=s*D(j,k), K(i,k)+=s*D(j,l), K(j,l)+=s*D(i,k), K(j,k)+=s*D(i,l).
   always_comb begin
      if (item_ff.mode == MODE_READ) begin
         k_row = item_ff.orb_i;
         k_col = item_ff.orb_j;
      end else begin
         k_row = cmd.upd[1] ? item_ff.orb_j : item_ff.orb_i;
         k_col = cmd.upd[0] ? item_ff.orb_k : item_ff.orb_l;
      end
      d_row = cmd.upd[1] ? item_ff.orb_i : item_ff.orb_j;
      d_col = cmd.upd[0] ? item_ff.orb_l : item_ff.orb_k;
   end

   assign k_addr = {item_ff.matrix_set, k_row, k_col};
   assign d_addr = {item_ff.matrix_set, d_row, d_col};
   assign scaled = prod_ff[PROD_W-1:FRAC_W];
   assign sum    = {kold_ff[ACC_W-1], kold_ff}
                 + (ACC_W + 1)'(scaled);
   assign sum_ovf = sum[ACC_W] != sum[ACC_W-1];

   always_comb begin
      if (!sum_ovf) begin
         sum_sat = sum[ACC_W-1:0];
      end else if (sum[ACC_W]) begin
         sum_sat = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

   always_comb begin
      k_wr_en   = 1'b0;
      k_wr_addr = k_addr;
      k_wr_data = sum_sat;
      priority if (cmd.clear_step) begin
         k_wr_en   = 1'b1;
         k_wr_addr = clr_ff;
         k_wr_data = '0;
      end else if (cmd.write_preset) begin
         k_wr_en   = 1'b1;
         k_wr_addr = {item_ff.matrix_set, item_ff.orb_i, item_ff.orb_j};
         k_wr_data = ACC_W'(item_ff.value);
      end else if (cmd.acc_write) begin
         k_wr_en = 1'b1;
      end
   end

   ecm_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_density (
      .clock   (clock),
      .wr_en   (cmd.write_density),
      .wr_addr ({item_ff.matrix_set, item_ff.orb_i, item_ff.orb_j}),
      .wr_data (item_ff.value),
      .rd_en   (cmd.issue_rd),
      .rd_addr (d_addr),
      .rd_data (d_rd_data)
   );

   ecm_ram #(.WIDTH(ACC_W), .DEPTH(STORE_DEPTH)) u_exchange (
      .clock   (clock),
      .wr_en   (k_wr_en),
      .wr_addr (k_wr_addr),
      .wr_data (k_wr_data),
      .rd_en   (cmd.issue_rd),
      .rd_addr (k_addr),
      .rd_data (k_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         orbitals_ff  <= ORBITALS_RESET;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            orbitals_ff <= csr_wr_data;
         end
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_payload;
         err_ff  <= err_in;
         sat_ff  <= 1'b0;
      end else if (cmd.acc_write && sum_ovf) begin
         sat_ff <= 1'b1;
      end
      if (cmd.mult) begin
         prod_ff <= $signed(item_ff.value) * $signed(d_rd_data);
         kold_ff <= $signed(k_rd_data);
      end
      if (cmd.rsp_load) begin
         rsp_ff.read_value  <= (item_ff.mode == MODE_READ && !err_ff) ? $signed(k_rd_data) : '0;
         rsp_ff.saturated   <= sat_ff || (cmd.acc_write && sum_ovf);
         rsp_ff.index_error <= err_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_ff;
   assign status.clear_last  = clr_ff == ADDR_W'(STORE_DEPTH - 1);
   assign status.err         = err_ff;
   assign status.mode        = item_ff.mode;
   assign status.rsp_busy    = rsp_valid_ff && rsp_stall;

endmodule
